/* rtl/assert_macros.svh */
// Assertion macros for the shadow memory access unit.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VSMA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define VSMA_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");
`else
`define VSMA_ASSERT(label, clk, rst_n, prop)
`define VSMA_NEVER(label, clk, rst_n, expr)
`endif
`endif

/* rtl/vsma_pkg.sv */
// Constants, register codes and state type of the shadow memory access unit.
// No dependencies.
package vsma_pkg;

    localparam int unsigned GRANULES  = 4096;
    localparam int unsigned ADDR_BITS = 48;
    localparam int unsigned AW        = 48;
    localparam int unsigned GIDX_W    = $clog2(GRANULES);
    localparam int unsigned SIZE_W    = 17;

    localparam longint unsigned CAP_BYTES = longint'(GRANULES) * 8;
    localparam logic [SIZE_W-1:0] SIZE_LIMIT =
        (CAP_BYTES < 65536) ? SIZE_W'(CAP_BYTES) : SIZE_W'(65536);
    localparam logic [AW-1:0] ADDR_MASK =
        (ADDR_BITS >= AW) ? '1 : AW'((64'd1 << ADDR_BITS) - 64'd1);

    localparam logic [4:0]  MAX_LEN    = 5'd16;
    localparam logic [63:0] STAMP_INIT = 64'd1;

    typedef logic [0:0] reg_idx_t;
    localparam reg_idx_t REG_BASE  = 1'b0;
    localparam reg_idx_t REG_BYTES = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_RANGE,
        ST_READ,
        ST_MERGE
    } state_t;

endpackage

/* rtl/versioned_shadow_memory_access_unit.sv */
// Shadow memory access unit: timing and interface. After reset the unit sweeps
// all GRANULES (4096) shadow slots to zero with busy high. A request is
// taken when start is high and busy is low. It then passes ST_CHECK and
// ST_RANGE; bypass and zero-length requests finish there, while a served
// access touching n shadow slots (n is 1 to 3) goes through ST_READ and
// ST_MERGE once per slot, as the single-port slot memory needs a read and a
// merge/write-back for each touched slot. busy drops in the cycle done is
// shown, so the next request can be taken then. Results appear for exactly
// one cycle with done and are not held for the receiver; the result ports
// keep their value only until the next request starts working.
`include "assert_macros.svh"

module versioned_shadow_memory_access_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                mode,
    input  logic [47:0]         address,
    input  logic [4:0]          length,
    input  logic [63:0]         wdata_low,
    input  logic [63:0]         wdata_high,
    output logic                done,
    output logic                status,
    output logic [63:0]         rdata_low,
    output logic [63:0]         rdata_high,
    output logic [63:0]         stamp,
    input  logic                cfg_we,
    input  vsma_pkg::reg_idx_t  cfg_index,
    input  logic [47:0]         cfg_data
);
    import vsma_pkg::*;

    state_t state_reg, state_next;

    logic [AW-1:0]      base_reg;
    logic [15:0]        bytes_reg;

    logic               mode_reg;
    logic [AW-1:0]      addr_reg;
    logic [4:0]         len_reg;
    logic [127:0]       wdat_reg;

    logic               under_reg;
    logic               big_reg;
    logic [15:0]        off_reg;

    logic [1:0]         slot_reg, slot_next;
    logic [GIDX_W-1:0]  clr_reg, clr_next;
    logic [63:0]        ctr_reg, ctr_next;
    logic [63:0]        rd_reg;
    logic [127:0]       racc_reg;
    logic               res_status_reg;
    logic [63:0]        res_stamp_reg;
    logic               done_reg;

    logic [63:0] slot_data  [GRANULES];
    logic [63:0] slot_stamp [GRANULES];

    logic [AW:0]        diff;
    logic [SIZE_W-1:0]  eff;
    logic [SIZE_W-1:0]  off_ext;
    logic [SIZE_W-1:0]  room;
    logic               len_zero;
    logic               bypass;
    logic               served_store;
    logic [2:0]         shift;
    logic [4:0]         last_sum;
    logic [1:0]         last_slot;
    logic               last_hit;
    logic [GIDX_W-1:0]  slot_idx;

    logic [4:0]         ld_pos [16];
    logic [5:0]         st_off [8];
    logic [127:0]       ld_lanes;
    logic [63:0]        merged;

    logic               mem_rd;
    logic               mem_we;
    logic [GIDX_W-1:0]  mem_addr;
    logic [63:0]        mem_wdata;
    logic [63:0]        mem_wstamp;
    logic               finish;

    // span check arithmetic
    always_comb
    begin
        diff         = {1'b0, addr_reg & ADDR_MASK} - {1'b0, base_reg & ADDR_MASK};
        eff          = ({1'b0, bytes_reg} > SIZE_LIMIT) ? SIZE_LIMIT : {1'b0, bytes_reg};
        off_ext      = {1'b0, off_reg};
        room         = eff - off_ext;
        len_zero     = (len_reg == 5'd0);
        bypass       = (len_reg > MAX_LEN) || (eff == '0) || under_reg || big_reg
                       || (off_ext >= eff) || (SIZE_W'(len_reg) > room);
        served_store = !len_zero && !bypass && mode_reg;
        shift        = off_reg[2:0];
        last_sum     = {2'b00, shift} + len_reg - 5'd1;
        last_slot    = last_sum[4:3];
        last_hit     = (slot_reg == last_slot);
        slot_idx     = GIDX_W'(off_reg >> 3) + GIDX_W'(slot_reg);
    end

    // byte lane steering for the slot in rd_reg
    always_comb
    begin
        ld_lanes = '0;
        merged   = rd_reg;
        for (int i = 0; i < 16; i++)
        begin
            ld_pos[i] = {2'b00, shift} + 5'(i);
            if ((ld_pos[i][4:3] == slot_reg) && (5'(i) < len_reg))
            begin
                ld_lanes[8*i +: 8] = rd_reg[{ld_pos[i][2:0], 3'b000} +: 8];
            end
        end
        for (int j = 0; j < 8; j++)
        begin
            st_off[j] = {1'b0, slot_reg, 3'(j)} - {3'b000, shift};
            if (!st_off[j][5] && (st_off[j][4:0] < len_reg))
            begin
                merged[8*j +: 8] = wdat_reg[{st_off[j][3:0], 3'b000} +: 8];
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == GIDX_W'(GRANULES - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
                state_next = ST_RANGE;
            ST_RANGE:
            begin
                if (len_zero || bypass)
                    state_next = ST_IDLE;
                else
                    state_next = ST_READ;
            end
            ST_READ:
                state_next = ST_MERGE;
            ST_MERGE:
            begin
                if (last_hit)
                    state_next = ST_IDLE;
                else
                    state_next = ST_READ;
            end
            default:
                state_next = ST_CLEAR;
        endcase
    end

    // state outputs
    always_comb
    begin
        busy       = 1'b1;
        mem_rd     = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = slot_idx;
        mem_wdata  = merged;
        mem_wstamp = res_stamp_reg;
        finish     = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we     = 1'b1;
                mem_addr   = clr_reg;
                mem_wdata  = '0;
                mem_wstamp = '0;
            end
            ST_IDLE:
                busy = 1'b0;
            ST_CHECK:
                busy = 1'b1;
            ST_RANGE:
                finish = len_zero || bypass;
            ST_READ:
                mem_rd = 1'b1;
            ST_MERGE:
            begin
                mem_we = mode_reg;
                finish = last_hit;
            end
            default:
                busy = 1'b1;
        endcase
    end

    always_comb
    begin
        clr_next  = clr_reg;
        slot_next = slot_reg;
        ctr_next  = ctr_reg;
        if (state_reg == ST_CLEAR)
            clr_next = clr_reg + GIDX_W'(1);
        if (state_reg == ST_RANGE)
        begin
            slot_next = 2'd0;
            if (served_store)
                ctr_next = ctr_reg + 64'd1;
        end
        if (state_reg == ST_MERGE)
            slot_next = slot_reg + 2'd1;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            slot_reg  <= '0;
            ctr_reg   <= STAMP_INIT;
            done_reg  <= 1'b0;
            base_reg  <= '0;
            bytes_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            slot_reg  <= slot_next;
            ctr_reg   <= ctr_next;
            done_reg  <= finish;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BASE:  base_reg  <= cfg_data[AW-1:0];
                    REG_BYTES: bytes_reg <= cfg_data[15:0];
                    default:   base_reg  <= base_reg;
                endcase
            end
        end
    end

    // request payload and results
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
        begin
            mode_reg <= mode;
            addr_reg <= address;
            len_reg  <= length;
            wdat_reg <= {wdata_high, wdata_low};
        end
        if (state_reg == ST_CHECK)
        begin
            under_reg <= diff[AW];
            big_reg   <= |diff[AW-1:16];
            off_reg   <= diff[15:0];
        end
        if (state_reg == ST_RANGE)
        begin
            racc_reg       <= '0;
            res_status_reg <= !len_zero && bypass;
            res_stamp_reg  <= served_store ? ctr_reg : 64'd0;
        end
        if ((state_reg == ST_MERGE) && !mode_reg)
            racc_reg <= racc_reg | ld_lanes;
    end

    // shadow slot memories, one port each
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_data[mem_addr]  <= mem_wdata;
            slot_stamp[mem_addr] <= mem_wstamp;
        end
        if (mem_rd)
            rd_reg <= slot_data[mem_addr];
    end

    assign done       = done_reg;
    assign status     = res_status_reg;
    assign rdata_low  = racc_reg[63:0];
    assign rdata_high = racc_reg[127:64];
    assign stamp      = res_stamp_reg;

    `VSMA_ASSERT(a_done_idle, clk, rst_n, done_reg |-> (state_reg == ST_IDLE))
    `VSMA_ASSERT(a_done_pulse, clk, rst_n, done_reg |=> !done_reg)
    `VSMA_ASSERT(a_bypass_zero, clk, rst_n, (done_reg && res_status_reg) |-> ((racc_reg == '0) && (res_stamp_reg == '0)))
    `VSMA_NEVER(a_slot_range, clk, rst_n, (state_reg == ST_MERGE) && (slot_reg > last_slot))

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for versioned_shadow_memory_access_unit.
// Directed rows, then random load/store phases, checked against an in-bench model or fixed values.
// Depends on vsma_pkg (register codes, granule count, address mask) and the unit's RTL.
module tb;

    import vsma_pkg::*;

    localparam logic        MODE_LOAD      = 1'b0;
    localparam logic        MODE_STORE     = 1'b1;
    localparam logic        STATUS_SERVED  = 1'b0;
    localparam logic        STATUS_BYPASS  = 1'b1;
    localparam logic [63:0] SHADOW_SPAN    = 64'(GRANULES) * 64'd8;
    localparam logic [63:0] ADDR_TOP       = 64'h1_0000_0000_0000;
    localparam int unsigned CYCLE_LIMIT    = 400000;
    localparam int unsigned SETTLE_CYCLES  = 12;
    localparam int unsigned MAX_PRINTED    = 30;

    typedef struct packed {
        logic        mode;
        logic [47:0] address;
        logic [4:0]  length;
        logic [63:0] wdata_low;
        logic [63:0] wdata_high;
    } access_req_t;

    typedef struct packed {
        logic        status;
        logic [63:0] rdata_low;
        logic [63:0] rdata_high;
        logic [63:0] stamp;
    } access_rsp_t;

    typedef struct packed {
        logic        is_cfg;
        reg_idx_t    cfg_index;
        logic [47:0] cfg_value;
        access_req_t req;
        logic        has_want;
        access_rsp_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        mode;
    logic [47:0] address;
    logic [4:0]  length;
    logic [63:0] wdata_low;
    logic [63:0] wdata_high;
    logic        done;
    logic        status;
    logic [63:0] rdata_low;
    logic [63:0] rdata_high;
    logic [63:0] stamp;
    logic        cfg_we;
    reg_idx_t    cfg_index;
    logic [47:0] cfg_data;

    // shadow model state
    logic [63:0] shadow_image [GRANULES];
    logic [63:0] stamp_counter;
    logic [47:0] region_base_q;
    logic [15:0] region_bytes_q;

    access_rsp_t responses_due[$];
    stim_row_t   directed_rows[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    logic        steady;

    versioned_shadow_memory_access_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .address    (address),
        .length     (length),
        .wdata_low  (wdata_low),
        .wdata_high (wdata_high),
        .done       (done),
        .status     (status),
        .rdata_low  (rdata_low),
        .rdata_high (rdata_high),
        .stamp      (stamp),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    endtask

    function automatic access_rsp_t predict_access(input access_req_t rq);
        access_rsp_t  rs;
        logic [63:0]  addr_w;
        logic [63:0]  base_w;
        logic [63:0]  span;
        logic [63:0]  off;
        logic [63:0]  pos;
        logic [127:0] wbytes;
        logic [127:0] rbytes;
        int unsigned  i;
        rs = '0;
        rbytes = '0;
        wbytes = {rq.wdata_high, rq.wdata_low};
        addr_w = 64'(rq.address & ADDR_MASK);
        base_w = 64'(region_base_q & ADDR_MASK);
        span = (64'(region_bytes_q) > SHADOW_SPAN) ? SHADOW_SPAN : 64'(region_bytes_q);
        if (rq.length == 5'd0)
            return rs;
        if (rq.length > MAX_LEN || span == 64'd0 || addr_w < base_w)
        begin
            rs.status = STATUS_BYPASS;
            return rs;
        end
        off = addr_w - base_w;
        if (off >= span || 64'(rq.length) > span - off)
        begin
            rs.status = STATUS_BYPASS;
            return rs;
        end
        if (rq.mode == MODE_STORE)
        begin
            rs.stamp = stamp_counter;
            stamp_counter = stamp_counter + 64'd1;
        end
        for (i = 0; i < rq.length; i++)
        begin
            pos = off + 64'(i);
            if (rq.mode == MODE_STORE)
                shadow_image[pos[GIDX_W+2:3]][pos[2:0]*8 +: 8] = wbytes[i*8 +: 8];
            else
                rbytes[i*8 +: 8] = shadow_image[pos[GIDX_W+2:3]][pos[2:0]*8 +: 8];
        end
        rs.rdata_low = rbytes[63:0];
        rs.rdata_high = rbytes[127:64];
        return rs;
    endfunction

    always @(posedge clk)
    begin : result_check
        access_rsp_t want;
        if (rst_n === 1'b1 && done !== 1'b0)
        begin
            if (responses_due.size() == 0)
                flag_mismatch("done with no request outstanding", 64'(done), 64'd0);
            else
            begin
                want = responses_due.pop_front();
                if (status !== want.status)
                    flag_mismatch("status", 64'(status), 64'(want.status));
                if (rdata_low !== want.rdata_low)
                    flag_mismatch("rdata_low", rdata_low, want.rdata_low);
                if (rdata_high !== want.rdata_high)
                    flag_mismatch("rdata_high", rdata_high, want.rdata_high);
                if (stamp !== want.stamp)
                    flag_mismatch("stamp", stamp, want.stamp);
            end
        end
    end

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic access_req_t make_request(input logic [47:0] base, input int unsigned eff);
        access_req_t rq;
        int unsigned len;
        int unsigned off;
        int unsigned lim;
        rq.mode = 1'($urandom_range(0, 1));
        rq.wdata_low = {$urandom, $urandom};
        rq.wdata_high = {$urandom, $urandom};
        if (eff == 0 || $urandom_range(0, 99) >= 85)
        begin
            // malformed or out-of-region requests
            case ($urandom_range(0, 4))
                0:
                begin
                    rq.length = 5'd0;
                    rq.address = base + 48'($urandom_range(0, 32));
                end
                1:
                begin
                    rq.length = 5'($urandom_range(17, 31));
                    rq.address = base + 48'($urandom_range(0, 16));
                end
                2:
                begin
                    rq.length = 5'($urandom_range(1, 16));
                    rq.address = base - 48'($urandom_range(1, 16));
                end
                3:
                begin
                    len = $urandom_range(2, 16);
                    rq.length = 5'(len);
                    rq.address = base + 48'(eff) - 48'($urandom_range(0, len - 1));
                end
                default:
                begin
                    rq.length = 5'($urandom_range(1, 16));
                    rq.address = rand48();
                end
            endcase
        end
        else
        begin
            lim = (eff < 16) ? eff : 16;
            len = $urandom_range(1, lim);
            if (eff > 256 && $urandom_range(0, 1) == 1)
            begin
                // keep wide regions hitting a few slots so loads see stored data
                if ($urandom_range(0, 1) == 1)
                    off = $urandom_range(0, 64);
                else
                    off = eff - len - $urandom_range(0, 64);
            end
            else
                off = $urandom_range(0, eff - len);
            rq.length = 5'(len);
            rq.address = base + 48'(off);
        end
        return rq;
    endfunction

    task automatic issue_request(input access_req_t rq, input logic has_want,
                                 input access_rsp_t typed_want);
        access_rsp_t want;
        start <= 1'b1;
        mode <= rq.mode;
        address <= rq.address;
        length <= rq.length;
        wdata_low <= rq.wdata_low;
        wdata_high <= rq.wdata_high;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        want = predict_access(rq);
        responses_due.insert(responses_due.size(), has_want ? typed_want : want);
    endtask

    task automatic pause_sender(input int unsigned gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drain everything in flight; the unit is idle afterwards
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (responses_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input reg_idx_t idx, input logic [47:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_BASE)
            region_base_q = value;
        else
            region_bytes_q = value[15:0];
        @(posedge clk);
    endtask

    task automatic add_cfg(input reg_idx_t idx, input logic [47:0] value);
        stim_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.cfg_index = idx;
        row.cfg_value = value;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic add_req(input logic md, input logic [47:0] addr, input logic [4:0] len,
                           input logic [63:0] lo, input logic [63:0] hi, input logic has_want,
                           input logic st, input logic [63:0] rlo, input logic [63:0] rhi,
                           input logic [63:0] stmp);
        stim_row_t row;
        row = '0;
        row.req = '{mode: md, address: addr, length: len, wdata_low: lo, wdata_high: hi};
        row.has_want = has_want;
        row.want = '{status: st, rdata_low: rlo, rdata_high: rhi, stamp: stmp};
        directed_rows.insert(directed_rows.size(), row);
    endtask

    initial
    begin : stimulus
        logic [47:0] base;
        logic [47:0] noise;
        logic [15:0] size_cfg;
        int unsigned eff;
        int unsigned count;
        int unsigned phase;
        int unsigned n;
        int unsigned i;

        rst_n <= 1'b0;
        start <= 1'b0;
        mode <= MODE_LOAD;
        address <= '0;
        length <= '0;
        wdata_low <= '0;
        wdata_high <= '0;
        cfg_we <= 1'b0;
        cfg_index <= REG_BASE;
        cfg_data <= '0;
        steady = 1'b0;
        for (i = 0; i < GRANULES; i++)
            shadow_image[i] = '0;
        stamp_counter = STAMP_INIT;
        region_base_q = '0;
        region_bytes_q = '0;

        // zero-size region straight out of reset: everything bypasses
        add_req(MODE_LOAD, 48'h0, 5'd4, '0, '0, 1'b1, STATUS_BYPASS, '0, '0, '0);
        add_req(MODE_STORE, 48'hFFFF_FFFF_FFFF, 5'd16, '1, '1, 1'b1, STATUS_BYPASS,
                '0, '0, '0);
        add_cfg(REG_BASE, 48'h0000_0000_1000);
        add_cfg(REG_BYTES, 48'd64);
        add_req(MODE_STORE, 48'h1000, 5'd16, '1, '1, 1'b1, STATUS_SERVED, '0, '0, 64'd1);
        add_req(MODE_LOAD, 48'h1000, 5'd16, '0, '0, 1'b1, STATUS_SERVED, '1, '1, '0);
        // zero length: served, nothing moves, counter holds
        add_req(MODE_LOAD, 48'h1000, 5'd0, '0, '0, 1'b1, STATUS_SERVED, '0, '0, '0);
        add_req(MODE_STORE, 48'h1000, 5'd0, '1, '1, 1'b1, STATUS_SERVED, '0, '0, '0);
        add_req(MODE_STORE, 48'h1000, 5'd17, '1, '1, 1'b1, STATUS_BYPASS, '0, '0, '0);
        add_req(MODE_LOAD, 48'h1000, 5'd31, '0, '0, 1'b1, STATUS_BYPASS, '0, '0, '0);
        add_req(MODE_LOAD, 48'h0FFF, 5'd1, '0, '0, 1'b1, STATUS_BYPASS, '0, '0, '0);
        add_req(MODE_LOAD, 48'h1040, 5'd1, '0, '0, 1'b1, STATUS_BYPASS, '0, '0, '0);
        add_req(MODE_STORE, 48'h103C, 5'd5, '1, '1, 1'b1, STATUS_BYPASS, '0, '0, '0);
        add_req(MODE_STORE, 48'h1030, 5'd16, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                1'b1, STATUS_SERVED, '0, '0, 64'd2);
        add_req(MODE_LOAD, 48'h1001, 5'd1, '0, '0, 1'b1, STATUS_SERVED, 64'hFF, '0, '0);
        // unaligned 16-byte store spans three slots
        add_req(MODE_STORE, 48'h1007, 5'd16, 64'h8877_6655_4433_2211, 64'h0FF0_E11E_D22D_C33C,
                1'b0, STATUS_SERVED, '0, '0, '0);
        add_req(MODE_LOAD, 48'h1006, 5'd16, '0, '0, 1'b0, STATUS_SERVED, '0, '0, '0);
        add_req(MODE_LOAD, 48'h103F, 5'd1, '0, '0, 1'b0, STATUS_SERVED, '0, '0, '0);
        // region at the top of the address space
        add_cfg(REG_BASE, 48'hFFFF_FFFF_FFC0);
        add_req(MODE_STORE, 48'hFFFF_FFFF_FFF0, 5'd16, 64'hA5A5_5A5A_C3C3_3C3C,
                64'h0F1E_2D3C_4B5A_6978, 1'b0, STATUS_SERVED, '0, '0, '0);
        add_req(MODE_LOAD, 48'hFFFF_FFFF_FFFF, 5'd1, '0, '0, 1'b0, STATUS_SERVED, '0, '0, '0);
        add_req(MODE_LOAD, 48'hFFFF_FFFF_FFF1, 5'd16, '0, '0, 1'b1, STATUS_BYPASS,
                '0, '0, '0);
        // oversized region is clamped to the shadow span
        add_cfg(REG_BASE, 48'h0);
        add_cfg(REG_BYTES, 48'h0000_0000_FFFF);
        add_req(MODE_LOAD, 48'h7FFF, 5'd1, '0, '0, 1'b0, STATUS_SERVED, '0, '0, '0);
        add_req(MODE_LOAD, 48'h8000, 5'd1, '0, '0, 1'b1, STATUS_BYPASS, '0, '0, '0);
        add_req(MODE_STORE, 48'h7FF0, 5'd16, 64'h1122_3344_5566_7788, 64'h99AA_BBCC_DDEE_FF00,
                1'b0, STATUS_SERVED, '0, '0, '0);
        add_req(MODE_LOAD, 48'h7FF8, 5'd16, '0, '0, 1'b0, STATUS_SERVED, '0, '0, '0);
        add_req(MODE_LOAD, 48'h0, 5'd16, '0, '0, 1'b0, STATUS_SERVED, '0, '0, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < directed_rows.size(); i++)
        begin
            if (directed_rows[i].is_cfg)
            begin
                settle();
                write_register(directed_rows[i].cfg_index, directed_rows[i].cfg_value);
            end
            else
            begin
                issue_request(directed_rows[i].req, directed_rows[i].has_want,
                              directed_rows[i].want);
                pause_sender(pick_gap());
            end
        end

        for (phase = 0; phase < 8; phase++)
        begin
            settle();
            base = rand48();
            case (phase)
                0: size_cfg = 16'($urandom_range(8, 64));
                1: size_cfg = 16'd1;
                2: size_cfg = 16'($urandom_range(65, 512));
                3: size_cfg = 16'(SHADOW_SPAN);
                4: size_cfg = 16'($urandom_range(32769, 65535));
                5: size_cfg = 16'd0;
                6: size_cfg = 16'($urandom_range(16, 128));
                default: size_cfg = 16'($urandom_range(17, 48));
            endcase
            eff = (64'(size_cfg) > SHADOW_SPAN) ? int'(SHADOW_SPAN) : int'(size_cfg);
            if (phase == 2)
                base = '0;
            else if (phase == 6)
                base = 48'(ADDR_TOP - 64'(eff));
            else if (64'(base) + 64'(eff) > ADDR_TOP)
                base = 48'(ADDR_TOP - 64'(eff));
            write_register(REG_BASE, base);
            noise = rand48();
            write_register(REG_BYTES, {noise[47:16], size_cfg});
            count = (phase == 5) ? 40 : 100;
            steady = ($urandom_range(0, 3) == 0);
            for (n = 0; n < count; n++)
            begin
                if ($urandom_range(0, 59) == 0)
                    settle();
                issue_request(make_request(base, eff), 1'b0, '0);
                if ($urandom_range(0, 39) == 0)
                    steady = !steady;
                pause_sender(pick_gap());
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/vsma_pkg.sv
rtl/versioned_shadow_memory_access_unit.sv
tb/sv/tb.sv
